### rtl/indexed_binary_heap_core_defines.svh
// Assertion macros for the indexed binary heap core.
// Depends on nothing; included by files that carry assertions.
`ifndef INDEXED_BINARY_HEAP_CORE_DEFINES_SVH
`define INDEXED_BINARY_HEAP_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define IBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define IBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ibh_pkg.sv
// Shared constants for the indexed binary heap core.
// Depends on nothing.
package ibh_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic [1:0] OP_READ     = 2'd0;
  localparam logic [1:0] OP_MODIFY   = 2'd1;
  localparam logic [1:0] OP_APPEND   = 2'd2;
  localparam logic [1:0] OP_READ_ALT = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

### rtl/indexed_binary_heap_core.sv
// Indexed binary heap core: keys stored by id, a heap of ids, maps both ways.
// Every path but the empty heap ends by reading the top entry: a read first looks up
// the key, an append sifts up, and a modify sifts up, then down from its old position.
// Throughput: one transaction at a time, the next one taken in the cycle after the result
// is issued. Synchronous reset empties the heap and sets min-heap order.
`include "indexed_binary_heap_core_defines.svh"

module indexed_binary_heap_core
  import ibh_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_id [7:0], key_value [39:8], zero fill [47:40]
  input  logic [47:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // key_at_id [31:0], assigned_id [39:32], top_id [47:40], top_key [79:48],
  // entry_count [88:80], zero fill [95:89]
  output logic [95:0]  m_axis_tdata,
  // status [1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int ID_W  = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KW    = KEY_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_R_KEY, S_M_POS,
    S_UP_A, S_UP_B, S_UP_C, S_UP_END,
    S_DN_INIT, S_DN_INIT2, S_DN_INIT3,
    S_DN_A, S_DN_B, S_DN_C, S_DN_D, S_DN_SEL, S_DN_CMP, S_DN_END,
    S_TOP_A, S_TOP_B, S_TOP_C, S_DONE
  } state_t;

  state_t state;

  logic                 order_max;
  logic [1:0]           opc;
  logic [7:0]           id_r;
  logic signed [KW-1:0] key_r;
  logic [CNT_W-1:0]     count;
  logic [ID_W-1:0]      p, pos0, par, par_id, cur_id, lid, rid, lpos, rpos, tid, tpos;
  logic signed [KW-1:0] cur_key, lkey, rkey, tkey, key_res, top_key_r;
  logic                 has_right;
  logic [1:0]           status_r;
  logic [7:0]           assigned_r;
  logic [ID_W-1:0]      top_id_r;

  logic                 k_we, p2i_we, i2p_we;
  logic [ID_W-1:0]      k_waddr, k_raddr, p2i_waddr, p2i_raddr, i2p_waddr, i2p_raddr;
  logic [ID_W-1:0]      p2i_wdata, i2p_wdata, p2i_rdata, i2p_rdata;
  logic signed [KW-1:0] k_wdata, k_rdata;
  logic signed [KW-1:0] cmp_a, cmp_b;
  logic                 ahead;

  logic [ID_W-1:0]      par_c;
  logic [CNT_W:0]       left_c, right_c;
  logic signed [KW-1:0] key_in;

  assign key_in  = KW'(signed'(s_axis_tdata[39:8]));
  assign par_c   = ID_W'((p - 1'b1) >> 1);
  assign left_c  = ((CNT_W + 1)'(p) << 1) + 1'b1;
  assign right_c = left_c + 1'b1;

  ibh_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  ibh_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_pos_to_id (
    .clk(clk), .we(p2i_we), .waddr(p2i_waddr), .wdata(p2i_wdata),
    .raddr(p2i_raddr), .rdata(p2i_rdata)
  );

  ibh_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_id_to_pos (
    .clk(clk), .we(i2p_we), .waddr(i2p_waddr), .wdata(i2p_wdata),
    .raddr(i2p_raddr), .rdata(i2p_rdata)
  );

  ibh_cmp #(.KEY_WIDTH(KW)) u_cmp (
    .order_max(order_max), .a(cmp_a), .b(cmp_b), .ahead(ahead)
  );

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    k_we      = 1'b0;
    k_waddr   = ID_W'(id_r);
    k_wdata   = key_r;
    k_raddr   = ID_W'(id_r);
    p2i_we    = 1'b0;
    p2i_waddr = p;
    p2i_wdata = cur_id;
    p2i_raddr = p;
    i2p_we    = 1'b0;
    i2p_waddr = cur_id;
    i2p_wdata = p;
    i2p_raddr = ID_W'(id_r);
    cmp_a     = cur_key;
    cmp_b     = tkey;
    unique case (state)
      S_DECODE: begin
        if (opc == OP_APPEND) begin
          k_waddr = ID_W'(count);
          k_we    = (count != CNT_W'(CAPACITY));
        end else begin
          k_we = (opc == OP_MODIFY) && (count != '0) && (32'(id_r) < 32'(count));
        end
      end
      S_UP_A:  p2i_raddr = par_c;
      S_UP_B:  k_raddr = p2i_rdata;
      S_UP_C: begin
        cmp_a = k_rdata;
        cmp_b = cur_key;
        if (!ahead) begin
          p2i_we    = 1'b1;
          p2i_wdata = par_id;
          i2p_we    = 1'b1;
          i2p_waddr = par_id;
        end
      end
      S_UP_END, S_DN_END: begin
        p2i_we = 1'b1;
        i2p_we = 1'b1;
      end
      S_DN_INIT2: k_raddr = p2i_rdata;
      S_DN_A:     p2i_raddr = ID_W'(left_c);
      S_DN_B: begin
        k_raddr   = p2i_rdata;
        p2i_raddr = rpos;
      end
      S_DN_C:   k_raddr = p2i_rdata;
      S_DN_SEL: begin
        cmp_a = lkey;
        cmp_b = rkey;
      end
      S_DN_CMP: begin
        if (!ahead) begin
          p2i_we    = 1'b1;
          p2i_wdata = tid;
          i2p_we    = 1'b1;
          i2p_waddr = tid;
        end
      end
      S_TOP_A: p2i_raddr = '0;
      S_TOP_B: k_raddr = p2i_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      order_max     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_max <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            opc   <= s_axis_tuser;
            id_r  <= s_axis_tdata[7:0];
            key_r <= key_in;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (opc == OP_APPEND) begin
            key_res <= key_r;
            if (count == CNT_W'(CAPACITY)) begin
              status_r   <= ST_FULL;
              assigned_r <= '0;
              state      <= S_TOP_A;
            end else begin
              status_r   <= ST_OK;
              cur_id     <= ID_W'(count);
              cur_key    <= key_r;
              p          <= ID_W'(count);
              count      <= count + 1'b1;
              assigned_r <= 8'(count);
              state      <= S_UP_A;
            end
          end else if (count == '0) begin
            status_r   <= ST_EMPTY;
            key_res    <= '0;
            assigned_r <= id_r;
            top_id_r   <= '0;
            top_key_r  <= '0;
            state      <= S_DONE;
          end else if (32'(id_r) >= 32'(count)) begin
            status_r   <= ST_RANGE;
            key_res    <= '0;
            assigned_r <= id_r;
            state      <= S_TOP_A;
          end else if (opc == OP_MODIFY) begin
            status_r   <= ST_OK;
            assigned_r <= id_r;
            cur_id     <= ID_W'(id_r);
            cur_key    <= key_r;
            key_res    <= key_r;
            state      <= S_M_POS;
          end else begin
            status_r   <= ST_OK;
            assigned_r <= id_r;
            state      <= S_R_KEY;
          end
        end
        S_R_KEY: begin
          key_res <= k_rdata;
          state   <= S_TOP_A;
        end
        S_M_POS: begin
          p     <= i2p_rdata;
          pos0  <= i2p_rdata;
          state <= S_UP_A;
        end
        S_UP_A: begin
          par   <= par_c;
          state <= (p == '0) ? S_UP_END : S_UP_B;
        end
        S_UP_B: begin
          par_id <= p2i_rdata;
          state  <= S_UP_C;
        end
        S_UP_C: begin
          if (ahead) begin
            state <= S_UP_END;
          end else begin
            p     <= par;
            state <= S_UP_A;
          end
        end
        S_UP_END: begin
          if (opc == OP_MODIFY) begin
            p     <= pos0;
            state <= S_DN_INIT;
          end else begin
            state <= S_TOP_A;
          end
        end
        S_DN_INIT:  state <= S_DN_INIT2;
        S_DN_INIT2: begin
          cur_id <= p2i_rdata;
          state  <= S_DN_INIT3;
        end
        S_DN_INIT3: begin
          cur_key <= k_rdata;
          state   <= S_DN_A;
        end
        S_DN_A: begin
          lpos      <= ID_W'(left_c);
          rpos      <= ID_W'(right_c);
          has_right <= (right_c < (CNT_W + 1)'(count));
          state     <= (left_c >= (CNT_W + 1)'(count)) ? S_DN_END : S_DN_B;
        end
        S_DN_B: begin
          lid   <= p2i_rdata;
          state <= S_DN_C;
        end
        S_DN_C: begin
          lkey  <= k_rdata;
          rid   <= p2i_rdata;
          state <= S_DN_D;
        end
        S_DN_D: begin
          rkey  <= k_rdata;
          state <= S_DN_SEL;
        end
        S_DN_SEL: begin
          if (!has_right || ahead) begin
            tid  <= lid;
            tkey <= lkey;
            tpos <= lpos;
          end else begin
            tid  <= rid;
            tkey <= rkey;
            tpos <= rpos;
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (ahead) begin
            state <= S_DN_END;
          end else begin
            p     <= tpos;
            state <= S_DN_A;
          end
        end
        S_DN_END: state <= S_TOP_A;
        S_TOP_A:  state <= S_TOP_B;
        S_TOP_B: begin
          top_id_r <= p2i_rdata;
          state    <= S_TOP_C;
        end
        S_TOP_C: begin
          top_key_r <= k_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid       <= 1'b1;
            m_axis_tuser        <= status_r;
            m_axis_tdata[31:0]  <= 32'(key_res);
            m_axis_tdata[39:32] <= assigned_r;
            m_axis_tdata[47:40] <= 8'(top_id_r);
            m_axis_tdata[79:48] <= 32'(top_key_r);
            m_axis_tdata[88:80] <= 9'(count);
            m_axis_tdata[95:89] <= '0;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IBH_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY),
                  "count exceeds capacity")
  `IBH_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                  "ready after accept")
  `IBH_ASSERT_NXT(a_append_count,
                  (state == S_DECODE) && (opc == OP_APPEND) && (count != CNT_W'(CAPACITY)),
                  count == CNT_W'($past(count) + 1'b1), "append did not grow count")
  `IBH_ASSERT_IMP(a_empty_result, m_axis_tvalid && (m_axis_tuser == ST_EMPTY),
                  m_axis_tdata[88:80] == 9'd0, "empty status with entries")

endmodule

### rtl/ibh_ram.sv
// Single-write, single-read memory with registered read data.
// Depends on nothing.
module ibh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ibh_cmp.sv
// Shared key comparator: true when key a is ordered before key b.
// Depends on nothing.
module ibh_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                        order_max,
  input  logic signed [KEY_WIDTH-1:0] a,
  input  logic signed [KEY_WIDTH-1:0] b,
  output logic                        ahead
);

  assign ahead = order_max ? (a > b) : (a < b);

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for indexed_binary_heap_core: reads, modifies and appends with
// random stream gaps, checked against a heap model kept in the testbench.
// Depends on ibh_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import ibh_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_at_id;
    logic [7:0]  assigned_id;
    logic [7:0]  top_id;
    logic [31:0] top_key;
    logic [8:0]  entry_count;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [31:0] keys[256];
    logic [7:0] pos_id[256];
    logic [7:0] id_pos[256];
    int count;
    bit order_max;
    heap_result_t pending[$];
    int mismatches;
    int checked;

    function bit ahead(logic signed [31:0] a, logic signed [31:0] b);
      return order_max ? (a > b) : (a < b);
    endfunction

    function logic signed [31:0] key_at(int p);
      return keys[pos_id[p]];
    endfunction

    function void swap_pos(int p, int q);
      logic [7:0] ia;
      logic [7:0] ib;
      ia = pos_id[p];
      ib = pos_id[q];
      pos_id[p] = ib;
      pos_id[q] = ia;
      id_pos[ia] = 8'(q);
      id_pos[ib] = 8'(p);
    endfunction

    function void rise(int p);
      int par;
      while (p > 0 && p < count) begin
        par = (p - 1) / 2;
        if (ahead(key_at(par), key_at(p))) break;
        swap_pos(par, p);
        p = par;
      end
    endfunction

    function void sink(int p);
      int l;
      int t;
      while (p < count) begin
        l = 2 * p + 1;
        if (l >= count) break;
        if (l + 1 >= count) t = l;
        else t = ahead(key_at(l), key_at(l + 1)) ? l : l + 1;
        if (ahead(key_at(p), key_at(t))) break;
        swap_pos(p, t);
        p = t;
      end
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] id, logic [31:0] key);
      heap_result_t r;
      int pos;
      r = '0;
      r.assigned_id = id;
      if (op == OP_APPEND) begin
        r.key_at_id = key;
        if (count >= 256) begin
          r.status = ST_FULL;
          r.assigned_id = '0;
        end else begin
          keys[count] = key;
          pos_id[count] = 8'(count);
          id_pos[count] = 8'(count);
          r.assigned_id = 8'(count);
          count++;
          rise(count - 1);
        end
      end else if (count == 0) begin
        r.status = ST_EMPTY;
      end else if (id >= count) begin
        r.status = ST_RANGE;
      end else begin
        if (op == OP_MODIFY) begin
          pos = id_pos[id];
          keys[id] = key;
          rise(pos);
          sink(pos);
        end
        r.key_at_id = keys[id];
      end
      if (count > 0) begin
        r.top_id = pos_id[0];
        r.top_key = key_at(0);
      end
      r.entry_count = 9'(count);
      pending = {pending, r};
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (exp !== got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected st=%0d key=%h aid=%0d top=%0d tkey=%h cnt=%0d,",
                   exp.status, exp.key_at_id, exp.assigned_id, exp.top_id, exp.top_key,
                   exp.entry_count);
          $display("          got st=%0d key=%h aid=%0d top=%0d tkey=%h cnt=%0d",
                   got.status, got.key_at_id, got.assigned_id, got.top_id,
                   got.top_key, got.entry_count);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic cfg_wr_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  heap_scoreboard heap_sb;
  int idle_cycles = 0;
  int sent;
  bit timed_out;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  indexed_binary_heap_core i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        heap_sb.check_result(heap_result_t'({m_axis_tuser, m_axis_tdata[31:0],
                             m_axis_tdata[39:32], m_axis_tdata[47:40],
                             m_axis_tdata[79:48], m_axis_tdata[88:80]}));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sink_side
    int g;
    wait (!rst);
    forever begin
      g = gap_len();
      if ($urandom_range(0, 3) == 0) g = 0;
      m_axis_tready <= (g == 0);
      repeat (g > 0 ? g : 1) @(posedge clk);
      m_axis_tready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_item(logic [1:0] op, logic [7:0] id, logic [31:0] key);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {8'h00, key, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    heap_sb.note_input(op, id, key);
    sent++;
  endtask

  task automatic drain_and_set(bit value);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (heap_sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    heap_sb.order_max = value;
  endtask

  function logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  function logic [1:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_APPEND;
    if (r < 75) return OP_MODIFY;
    if (r < 97) return OP_READ;
    return OP_READ_ALT;
  endfunction

  task automatic random_phase(int n, int fill_to);
    logic [7:0] id;
    for (int i = 0; i < n; i++) begin
      if (heap_sb.count < fill_to && $urandom_range(0, 1)) begin
        send_item(OP_APPEND, 0, rand_key());
      end else begin
        if (heap_sb.count > 0 && $urandom_range(0, 9) != 0)
          id = 8'($urandom_range(0, heap_sb.count - 1));
        else
          id = 8'($urandom);
        send_item(rand_op(), id, rand_key());
      end
    end
  endtask

  initial begin : stimulus
    heap_sb = new();
    sent = 0;
    timed_out = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(OP_READ, 0, 0);
    send_item(OP_MODIFY, 0, 5);
    send_item(OP_READ_ALT, 8'hff, 0);
    send_item(OP_APPEND, 0, 32'h7fff_ffff);
    send_item(OP_APPEND, 0, 32'h8000_0000);
    send_item(OP_APPEND, 0, 0);
    send_item(OP_APPEND, 0, 0);
    send_item(OP_APPEND, 0, 32'hffff_ffff);
    send_item(OP_READ, 3, 0);
    send_item(OP_READ, 5, 0);
    send_item(OP_MODIFY, 8'hff, 1);
    send_item(OP_MODIFY, 1, 32'h7fff_ffff);
    send_item(OP_MODIFY, 0, 32'h8000_0000);
    send_item(OP_MODIFY, 2, 32'hffff_ffff);
    send_item(OP_READ_ALT, 4, 0);
    drain_and_set(1);
    send_item(OP_MODIFY, 3, 32'h7fff_fffe);
    send_item(OP_MODIFY, 4, 32'h7fff_fffe);
    send_item(OP_APPEND, 8'hff, 32'h5555_aaaa);
    random_phase(250, 60);
    drain_and_set(0);
    random_phase(300, 140);
    drain_and_set(1);
    random_phase(200, 200);
    drain_and_set(0);
    while (heap_sb.count < 256) send_item(OP_APPEND, 0, rand_key());
    send_item(OP_APPEND, 0, 32'h1234_5678);
    send_item(OP_READ, 255, 0);
    random_phase(280, 256);
    s_axis_tvalid <= 0;
    while (heap_sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results over min and max order.",
             sent, heap_sb.checked);
    if (heap_sb.mismatches == 0 && !timed_out) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    wait (idle_cycles >= 20000);
    timed_out = 1;
    $display("Timeout after %0d idle cycles.", idle_cycles);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
